// File: rtl/lzwd_pkg.sv
// lzwd_pkg: shared types, constants and helpers for the 12-bit LZW decoder
// depends on nothing; used by the memories, the parser, the top level and the bench

package lzwd_pkg;

  // stream and table geometry
  localparam int DICT_ENTRIES = 4096;
  localparam int STACK_DEPTH  = 4096;
  localparam int FIRST_CODE   = 256;
  localparam int DICT_SLOTS   = DICT_ENTRIES - FIRST_CODE;
  localparam int DICT_AW      = $clog2(DICT_SLOTS);
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int CODE_W       = 12;
  localparam int NF_W         = CODE_W + 1;
  localparam int CNT_W        = STACK_AW + 1;
  localparam int REM_W        = 15;

  // item commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_BYTE    = 2'd0;
  localparam logic [1:0] STAT_NEED    = 2'd1;
  localparam logic [1:0] STAT_TAKEN   = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR_LO,
    PH_HDR_HI,
    PH_LOW_A,
    PH_LOW_B,
    PH_HIGH
  } parse_phase_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_POP,
    DS_WALK
  } dec_state_t;

  // one dictionary entry: predecessor code and appended symbol
  typedef struct packed {
    logic [CODE_W-1:0] prev;
    logic [7:0]        sym;
  } dict_ent_t;

  // parser status seen by the decode control
  typedef struct packed {
    logic              pend_valid;
    logic [CODE_W-1:0] pend_code;
    logic              new_block;
  } parse_stat_t;

  // header word divided by 3, by reciprocal multiply (exact for 16-bit words)
  function automatic logic [REM_W-1:0] div3(input logic [15:0] w);
    logic [31:0] p;
    p = 32'(w) * 32'd43691;
    return p[31:17];
  endfunction

endpackage

// File: rtl/lzwd_if.sv
// lzwd_req_if / lzwd_rsp_if: valid/ready channels for the decoder items
// depends on nothing; plain widths only, no package types

interface lzwd_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface lzwd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

// File: rtl/lzwd_dict_mem.sv
// lzwd_dict_mem: dictionary RAM, one entry per code above the byte codes
// depends on lzwd_pkg; registered synchronous read, separate write and read ports

module lzwd_dict_mem
  import lzwd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [DICT_AW-1:0] waddr,
  input  dict_ent_t          wdata,
  input  logic               re,
  input  logic [DICT_AW-1:0] raddr,
  output dict_ent_t          rdata
);

  dict_ent_t mem [DICT_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lzwd_stack_mem.sv
// lzwd_stack_mem: byte stack RAM that reverses the walked chain
// depends on lzwd_pkg; registered synchronous read

module lzwd_stack_mem
  import lzwd_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [STACK_AW-1:0] waddr,
  input  logic [7:0]          wdata,
  input  logic                re,
  input  logic [STACK_AW-1:0] raddr,
  output logic [7:0]          rdata
);

  logic [7:0] mem [STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lzwd_parser.sv
// lzwd_parser: block header and 12-bit code unpacking from pushed bytes
// depends on lzwd_pkg; holds one pending code until the decode control takes it

module lzwd_parser
  import lzwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  push_byte,
  input  logic        take,
  output parse_stat_t stat
);

  parse_phase_t      phase, phase_next;
  logic [7:0]        low, low_next;
  logic [3:0]        nib, nib_next;
  logic [REM_W-1:0]  remaining, remaining_next;
  logic              pend_valid, pend_valid_next;
  logic [CODE_W-1:0] pend_code, pend_code_next;
  logic              new_block;
  logic              live_push;
  logic [REM_W-1:0]  rem_dec;
  logic [REM_W-1:0]  hdr_count;

  assign live_push = push && !pend_valid;
  assign rem_dec   = remaining - REM_W'(1);
  assign hdr_count = div3({push_byte, low});

  // phase sequencing and code assembly
  always_comb begin
    phase_next      = phase;
    low_next        = low;
    nib_next        = nib;
    remaining_next  = remaining;
    pend_valid_next = pend_valid;
    pend_code_next  = pend_code;
    new_block       = 1'b0;
    if (take) begin
      pend_valid_next = 1'b0;
    end
    if (live_push) begin
      case (phase)
        PH_HDR_LO: begin
          low_next   = push_byte;
          phase_next = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          remaining_next = hdr_count;
          new_block      = 1'b1;
          phase_next     = (hdr_count != '0) ? PH_LOW_A : PH_HDR_LO;
        end
        PH_LOW_A: begin
          low_next   = push_byte;
          phase_next = PH_LOW_B;
        end
        PH_LOW_B: begin
          nib_next        = push_byte[7:4];
          pend_code_next  = {push_byte[3:0], low};
          pend_valid_next = 1'b1;
          remaining_next  = rem_dec;
          phase_next      = (rem_dec != '0) ? PH_HIGH : PH_HDR_LO;
        end
        PH_HIGH: begin
          pend_code_next  = {push_byte, nib};
          pend_valid_next = 1'b1;
          remaining_next  = rem_dec;
          phase_next      = (rem_dec != '0) ? PH_LOW_A : PH_HDR_LO;
        end
        default: begin
          phase_next = PH_HDR_LO;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR_LO;
      low        <= '0;
      nib        <= '0;
      remaining  <= '0;
      pend_valid <= 1'b0;
      pend_code  <= '0;
    end else begin
      phase      <= phase_next;
      low        <= low_next;
      nib        <= nib_next;
      remaining  <= remaining_next;
      pend_valid <= pend_valid_next;
      pend_code  <= pend_code_next;
    end
  end

  assign stat.pend_valid = pend_valid;
  assign stat.pend_code  = pend_code;
  assign stat.new_block  = new_block;

endmodule

// File: rtl/lzw_fixed12_block_decoder_core.sv
// lzw_fixed12_block_decoder_core: top level of the 12-bit LZW block decoder
// depends on lzwd_pkg, lzwd_if, lzwd_parser, lzwd_dict_mem and lzwd_stack_mem
//
// Usage: every item on req carries cmd and in_byte; every item gives exactly one
// item on rsp (out_byte, status). cmd 0 pushes one compressed byte and answers
// "byte accepted", or "byte refused" while a parsed code waits to be decoded.
// cmd 1 pulls one decoded byte: it pops the byte stack, or decodes the pending
// code, or answers "input needed".
// Push and "input needed" items load the result register directly; a pop
// reads the stack RAM first; decoding a code whose chain reaches above the byte
// codes walks that chain, one dictionary RAM read per cycle.
// A new item is taken when the decoder is idle and the result register is empty
// or being emptied; a stalled receiver simply holds the result and req.ready.
// Reset (synchronous rst) empties the stack, the result register and the
// pending code, and waits for a block header; the dictionary needs no clearing
// pass because entries at or above the fill mark read as predecessor 0, byte 0.

module lzw_fixed12_block_decoder_core
  import lzwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lzwd_req_if.sink   req,
  lzwd_rsp_if.source rsp
);

  dec_state_t        state, state_next;
  logic [NF_W-1:0]   next_free;
  logic              block_start;
  logic [CODE_W-1:0] prev_code;
  logic [7:0]        last_first;
  logic [CNT_W-1:0]  stack_count;
  logic [CODE_W-1:0] walk;
  logic [CODE_W-1:0] cur_code;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic [1:0]        out_status;

  parse_stat_t       pst;
  dict_ent_t         dict_rd, dict_wd;
  logic              dict_we, dict_re;
  logic [DICT_AW-1:0] dict_waddr, dict_raddr;
  logic              stk_we, stk_re;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]        stk_wd, stk_rd;

  logic              acc, ev_push, ev_pop, ev_dec, ev_need;
  logic              kw, walk0_big, fin_idle, fin_walk, finish, stk_full;
  logic              ent_live, ent_prev_big;
  logic [CODE_W-1:0] walk0, ent_prev, code_now, rd_code;
  logic [7:0]        ent_sym, first, bs_first;
  logic              load_out;
  logic [7:0]        load_byte;
  logic [1:0]        load_status;

  // input handshake and item decode
  assign req.ready = (state == DS_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign ev_push   = acc && (req.cmd == CMD_PUSH);
  assign ev_pop    = acc && (req.cmd == CMD_PULL) && (stack_count != '0);
  assign ev_dec    = acc && (req.cmd == CMD_PULL) && (stack_count == '0) && pst.pend_valid;
  assign ev_need   = acc && (req.cmd == CMD_PULL) && (stack_count == '0) && !pst.pend_valid;

  lzwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_byte (req.in_byte),
    .take      (ev_dec),
    .stat      (pst)
  );

  // start of a decode: code not yet defined falls back on the previous code
  assign kw        = {1'b0, pst.pend_code} >= next_free;
  assign walk0     = kw ? prev_code : pst.pend_code;
  assign walk0_big = walk0 >= CODE_W'(FIRST_CODE);
  assign bs_first  = (pst.pend_code < CODE_W'(FIRST_CODE)) ? pst.pend_code[7:0] : 8'd0;
  assign fin_idle  = ev_dec && !block_start && !walk0_big;

  // chain step: entries at or above the fill mark read as zero
  assign ent_live     = {1'b0, walk} < next_free;
  assign ent_sym      = ent_live ? dict_rd.sym : 8'd0;
  assign ent_prev     = ent_live ? dict_rd.prev : '0;
  assign ent_prev_big = ent_prev >= CODE_W'(FIRST_CODE);
  assign stk_full     = stack_count == CNT_W'(STACK_DEPTH);
  assign fin_walk     = (state == DS_WALK) && (stk_full || !ent_prev_big);

  // end of a decode: first byte and the new dictionary entry
  assign finish   = fin_idle || fin_walk;
  assign first    = fin_idle ? walk0[7:0] : (stk_full ? ent_sym : ent_prev[7:0]);
  assign code_now = (state == DS_IDLE) ? pst.pend_code : cur_code;

  // dictionary port control
  assign rd_code    = (state == DS_IDLE) ? walk0 : ent_prev;
  assign dict_re    = (ev_dec && !block_start && walk0_big) || ((state == DS_WALK) && !fin_walk);
  assign dict_raddr = DICT_AW'(rd_code - CODE_W'(FIRST_CODE));
  assign dict_we    = finish && (next_free < NF_W'(DICT_ENTRIES));
  assign dict_waddr = DICT_AW'(next_free - NF_W'(FIRST_CODE));
  assign dict_wd    = '{prev: prev_code, sym: first};

  lzwd_dict_mem u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wd),
    .re    (dict_re),
    .raddr (dict_raddr),
    .rdata (dict_rd)
  );

  // stack port control: pushes during a decode, pops on pull items
  always_comb begin
    stk_we = 1'b0;
    stk_wd = last_first;
    if (ev_dec && !block_start && kw) begin
      stk_we = 1'b1;
    end else if ((state == DS_WALK) && !stk_full) begin
      stk_we = 1'b1;
      stk_wd = ent_sym;
    end
  end

  assign stk_waddr = stack_count[STACK_AW-1:0];
  assign stk_re    = ev_pop;
  assign stk_raddr = STACK_AW'(stack_count - CNT_W'(1));

  lzwd_stack_mem u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wd),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      DS_IDLE: begin
        if (ev_pop) begin
          state_next = DS_POP;
        end else if (ev_dec && !block_start && walk0_big) begin
          state_next = DS_WALK;
        end
      end
      DS_POP: begin
        state_next = DS_IDLE;
      end
      DS_WALK: begin
        if (fin_walk) begin
          state_next = DS_IDLE;
        end
      end
      default: begin
        state_next = DS_IDLE;
      end
    endcase
  end

  // result selection
  always_comb begin
    load_out    = 1'b0;
    load_byte   = 8'd0;
    load_status = STAT_BYTE;
    case (state)
      DS_IDLE: begin
        if (ev_push) begin
          load_out    = 1'b1;
          load_status = pst.pend_valid ? STAT_REFUSED : STAT_TAKEN;
        end else if (ev_need) begin
          load_out    = 1'b1;
          load_status = STAT_NEED;
        end else if (ev_dec && block_start) begin
          load_out  = 1'b1;
          load_byte = bs_first;
        end else if (fin_idle) begin
          load_out  = 1'b1;
          load_byte = first;
        end
      end
      DS_POP: begin
        load_out  = 1'b1;
        load_byte = stk_rd;
      end
      DS_WALK: begin
        if (fin_walk) begin
          load_out  = 1'b1;
          load_byte = first;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= DS_IDLE;
      next_free   <= NF_W'(FIRST_CODE);
      block_start <= 1'b1;
      prev_code   <= '0;
      last_first  <= '0;
      stack_count <= '0;
      walk        <= '0;
      cur_code    <= '0;
    end else begin
      state <= state_next;
      if (pst.new_block) begin
        next_free   <= NF_W'(FIRST_CODE);
        block_start <= 1'b1;
      end
      if (ev_dec) begin
        cur_code <= pst.pend_code;
      end
      if (ev_dec && block_start) begin
        block_start <= 1'b0;
        prev_code   <= pst.pend_code;
        last_first  <= bs_first;
      end
      if (dict_re) begin
        walk <= rd_code;
      end
      if (finish) begin
        prev_code  <= code_now;
        last_first <= first;
      end
      if (dict_we) begin
        next_free <= next_free + NF_W'(1);
      end
      if (stk_we) begin
        stack_count <= stack_count + CNT_W'(1);
      end else if (ev_pop) begin
        stack_count <= stack_count - CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte   <= load_byte;
      out_status <= load_status;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.status   = out_status;

endmodule

// File: tb/lzw_fixed12_block_decoder_core_tb.sv
// lzw_fixed12_block_decoder_core_tb: self-checking bench for the 12-bit LZW block decoder
// depends on lzwd_pkg, lzwd_if and the core; a built-in decoder model checks every result item
// covers empty blocks, first codes, undefined codes, unwritten entries, full table, full stack

module lzw_fixed12_block_decoder_core_tb
  import lzwd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    MAX_CODE       = (1 << CODE_W) - 1;
  localparam int    RANDOM_ITEMS   = 900;
  localparam int    RX_HOLD_CYCLES = 300;
  localparam int    DRAIN_CYCLES   = 32;
  localparam int    MAX_REPORTS    = 40;
  localparam longint RUN_LIMIT_NS  = 64'd30_000_000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzwd_req_if req_ch ();
  lzwd_rsp_if rsp_ch ();

  lzw_fixed12_block_decoder_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [CODE_W-1:0]    m_prev [DICT_SLOTS];
  logic [7:0]           m_sym [DICT_SLOTS];
  logic [DICT_SLOTS-1:0] m_live = '0;
  logic [7:0]           m_stack [STACK_DEPTH];
  int                   m_depth = 0;
  int                   m_next_free = FIRST_CODE;
  parse_phase_t         m_phase = PH_HDR_LO;
  logic [7:0]           m_hdr_lo = 8'h00;
  int                   m_codes_left = 0;
  logic [15:0]          m_bits = 16'h0000;
  logic                 m_pend_valid = 1'b0;
  logic [CODE_W-1:0]    m_pend_code = '0;
  int                   m_last_code = 0;
  logic [7:0]           m_last_first = 8'h00;
  logic                 m_fresh_block = 1'b1;

  // answers owed by the decoder, oldest first
  answer_t answer_q[$];

  // compressed stream still to be pushed, and codes of the block being built
  logic [7:0] stream_q[$];
  int         code_q[$];

  int   err_count = 0;
  int   tx_count = 0;
  int   tx_burst = 0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   rx_hold_req = 1'b0;

  function automatic bit entry_live(input int c);
    return c >= FIRST_CODE && c < DICT_ENTRIES && m_live[c - FIRST_CODE];
  endfunction

  function automatic logic [7:0] entry_sym(input int c);
    if (c < FIRST_CODE) return 8'(c);
    return entry_live(c) ? m_sym[c - FIRST_CODE] : 8'h00;
  endfunction

  function automatic int entry_pred(input int c);
    return entry_live(c) ? int'(m_prev[c - FIRST_CODE]) : 0;
  endfunction

  function automatic void stack_byte(input logic [7:0] b);
    if (m_depth < STACK_DEPTH) begin
      m_stack[m_depth] = b;
      m_depth++;
    end
  endfunction

  function automatic void code_done();
    m_pend_valid = 1'b1;
    m_pend_code  = m_bits[CODE_W-1:0];
    m_codes_left--;
  endfunction

  // expand one code onto the stack, grow the table, return the byte handed out now
  function automatic logic [7:0] expand_code(input int code);
    int         w;
    logic [7:0] head;
    if (m_fresh_block) begin
      m_fresh_block = 1'b0;
      head = entry_sym(code);
    end else begin
      if (code >= m_next_free) begin
        stack_byte(m_last_first);
        w = m_last_code;
      end else begin
        w = code;
      end
      while (w >= FIRST_CODE && m_depth < STACK_DEPTH) begin
        stack_byte(entry_sym(w));
        w = entry_pred(w);
      end
      head = entry_sym(w);
      if (m_next_free < DICT_ENTRIES) begin
        m_prev[m_next_free - FIRST_CODE] = CODE_W'(m_last_code);
        m_sym[m_next_free - FIRST_CODE]  = head;
        m_live[m_next_free - FIRST_CODE] = 1'b1;
        m_next_free++;
      end
    end
    m_last_code  = code;
    m_last_first = head;
    return head;
  endfunction

  // answer of the decoder to one item, advancing the model
  function automatic answer_t lzw_step(input logic c, input logic [7:0] b);
    answer_t a;
    int      w;
    a.out_byte = 8'h00;
    if (c == CMD_PUSH) begin
      if (m_pend_valid) begin
        a.status = STAT_REFUSED;
      end else begin
        a.status = STAT_TAKEN;
        case (m_phase)
          PH_HDR_LO: begin
            m_hdr_lo = b;
            m_phase  = PH_HDR_HI;
          end
          PH_HDR_HI: begin
            w = int'({b, m_hdr_lo});
            m_codes_left  = w / 3;
            m_live        = '0;
            m_next_free   = FIRST_CODE;
            m_fresh_block = 1'b1;
            m_phase = (m_codes_left != 0) ? PH_LOW_A : PH_HDR_LO;
          end
          PH_LOW_A: begin
            m_bits  = {8'h00, b};
            m_phase = PH_LOW_B;
          end
          PH_LOW_B: begin
            m_bits[15:8] = b;
            code_done();
            m_phase = (m_codes_left != 0) ? PH_HIGH : PH_HDR_LO;
          end
          default: begin
            m_bits = {4'h0, b, m_bits[15:12]};
            code_done();
            m_phase = (m_codes_left != 0) ? PH_LOW_A : PH_HDR_LO;
          end
        endcase
      end
    end else if (m_depth > 0) begin
      m_depth--;
      a.out_byte = m_stack[m_depth];
      a.status   = STAT_BYTE;
    end else if (m_pend_valid) begin
      m_pend_valid = 1'b0;
      a.out_byte   = expand_code(int'(m_pend_code));
      a.status     = STAT_BYTE;
    end else begin
      a.status = STAT_NEED;
    end
    return a;
  endfunction

  // header word, then codes in 3-byte pairs; an odd last code gets 2 bytes with a junk nibble
  function automatic void pack_block(input int slack);
    int                n;
    int                w;
    logic [CODE_W-1:0] ca;
    logic [CODE_W-1:0] cb;
    n = code_q.size();
    w = n * 3 + slack;
    stream_q.push_back(8'(w));
    stream_q.push_back(8'(w >> 8));
    for (int i = 0; i < n; i += 2) begin
      ca = CODE_W'(code_q[i]);
      stream_q.push_back(ca[7:0]);
      if (i + 1 < n) begin
        cb = CODE_W'(code_q[i + 1]);
        stream_q.push_back({cb[3:0], ca[11:8]});
        stream_q.push_back(cb[11:4]);
      end else begin
        stream_q.push_back({4'($urandom), ca[11:8]});
      end
    end
    code_q.delete();
  endfunction

  // codes that a real encoder could emit, or random codes for a garbled block
  function automatic void gen_codes(input int n, input bit garbled);
    int nf;
    int r;
    nf = FIRST_CODE;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (garbled) begin
        code_q.push_back(int'($urandom_range(0, MAX_CODE)));
      end else if (i == 0) begin
        code_q.push_back(r < 95 ? int'($urandom_range(0, 255))
                                : int'($urandom_range(FIRST_CODE, MAX_CODE)));
      end else if (r < 45) begin
        code_q.push_back(int'($urandom_range(0, 255)));
      end else if (r < 88 && nf > FIRST_CODE) begin
        code_q.push_back(int'($urandom_range(FIRST_CODE, nf - 1)));
      end else if (nf < DICT_ENTRIES) begin
        code_q.push_back(nf);
      end else begin
        code_q.push_back(int'($urandom_range(0, 255)));
      end
      if (i > 0 && nf < DICT_ENTRIES) nf++;
    end
  endfunction

  // offer one item in bursts with gaps, wait for acceptance, log the answer owed
  task automatic send_item(input logic c, input logic [7:0] b, output logic [1:0] st);
    answer_t a;
    int      gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (!tx_steady && gap != 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    tx_burst--;
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.in_byte <= b;
    do @(posedge clk); while (!req_ch.ready);
    a = lzw_step(c, b);
    answer_q.push_back(a);
    tx_count++;
    st = a.status;
  endtask

  // push the stream, pulling whatever the decoder holds; some early pushes and idle pulls
  task automatic feed_stream(input int early_push_pct);
    logic [1:0] st;
    logic       c;
    while (stream_q.size() != 0 || m_depth != 0 || m_pend_valid) begin
      if (m_depth != 0 || m_pend_valid)
        c = (stream_q.size() != 0 && $urandom_range(0, 99) < early_push_pct) ? CMD_PUSH : CMD_PULL;
      else
        c = (stream_q.size() == 0 || $urandom_range(0, 11) == 0) ? CMD_PULL : CMD_PUSH;
      if (c == CMD_PUSH) begin
        send_item(CMD_PUSH, stream_q[0], st);
        if (st == STAT_TAKEN) void'(stream_q.pop_front());
      end else begin
        send_item(CMD_PULL, 8'($urandom), st);
      end
    end
  endtask

  // empty decoder, empty blocks, literals, known entries, code at next free, undefined code,
  // first code above the byte range, chain through an unwritten entry
  task automatic test_directed();
    logic [1:0] st;
    send_item(CMD_PULL, 8'h00, st);
    send_item(CMD_PULL, 8'hff, st);
    stream_q = {8'h00, 8'h00, 8'h02, 8'h00};
    code_q = {'h041, 'h042, 'h100, 'h102, MAX_CODE};
    pack_block(0);
    code_q = {MAX_CODE, 'h0ff, 'h100};
    pack_block(2);
    feed_stream(50);
  endtask

  // fill the table with literals, then use the last entry once no entry can be added
  task automatic test_full_table();
    repeat (DICT_SLOTS + 1) code_q.push_back(int'($urandom_range(0, 255)));
    code_q.push_back(MAX_CODE);
    code_q.push_back('h300);
    code_q.push_back(MAX_CODE);
    pack_block(0);
    feed_stream(5);
  endtask

  // an undefined code makes an entry its own predecessor; walking it fills the stack
  task automatic test_full_stack();
    code_q = {'h041, 'h101, 'h042, 'h101};
    pack_block(1);
    feed_stream(5);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    tx_steady = 1'b1;
    gen_codes(20, 1'b0);
    pack_block(0);
    rx_hold_req = 1'b1;
    feed_stream(10);
    tx_steady = 1'b0;
  endtask

  // mostly well-formed blocks, some empty or garbled; a truncated huge block at the end
  task automatic test_random_stream();
    int first_item;
    int pick;
    int w;
    first_item = tx_count;
    while (tx_count - first_item < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        w = $urandom_range(0, 2);
        stream_q.push_back(8'(w));
        stream_q.push_back(8'h00);
      end else begin
        if (pick < 18) gen_codes($urandom_range(1, 24), 1'b1);
        else if (pick < 26) gen_codes($urandom_range(60, 150), 1'b0);
        else gen_codes($urandom_range(1, 24), 1'b0);
        pack_block($urandom_range(0, 2));
      end
      feed_stream(10);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    stream_q = {8'hff, 8'hff};
    repeat (60) stream_q.push_back(8'($urandom));
    feed_stream(10);
  endtask

  // receiver: random ready pattern, steady stretches, and one long hold on request
  initial begin : rx_pattern
    int run;
    bit on;
    rsp_ch.ready = 1'b0;
    run = 0;
    on = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (rx_steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          on = !on;
          run = on ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        run--;
        rsp_ch.ready <= on;
      end
    end
  end

  // compare each result item with the oldest answer owed
  always @(posedge clk) begin : rsp_check
    answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answer_q.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: result with nothing outstanding: status %0d byte %02h",
                   $time, rsp_ch.status, rsp_ch.out_byte);
        err_count++;
      end else begin
        want = answer_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.out_byte !== want.out_byte) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: out_byte expected %02h got %02h",
                     $time, want.out_byte, rsp_ch.out_byte);
          err_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    req_ch.valid   = 1'b0;
    req_ch.cmd     = CMD_PUSH;
    req_ch.in_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_stack();
    test_backpressure();
    test_full_table();
    test_random_stream();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("lzw_fixed12_block_decoder_core_tb: clean");
    else
      $display("lzw_fixed12_block_decoder_core_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("lzw_fixed12_block_decoder_core_tb: errors");
    $finish;
  end

endmodule
